@@ rtl/core/aclk_pkg.sv @@
// ----------------------------------------------------------------------------
// aclk_pkg - alarm clock shared definitions
// Event codes, mode codes, limits and the result record used by the core and
// the top level.
// ----------------------------------------------------------------------------
package aclk_pkg;

  localparam int unsigned PrescaleW = 10;
  localparam int unsigned HourW     = 5;
  localparam int unsigned MinW      = 6;
  localparam int unsigned ShadowW   = 7;

  localparam logic [PrescaleW-1:0] PRESCALE_RST   = 10'd977;
  localparam logic [5:0]           SEC_MAX        = 6'd59;
  localparam logic [5:0]           MIN_MAX        = 6'd59;
  localparam logic [5:0]           HOUR_MAX       = 6'd23;
  localparam logic [HourW-1:0]     HOUR_UNSET     = 5'd31;
  localparam logic [ShadowW-1:0]   SHADOW_CLEARED = 7'd127;

  typedef enum logic [2:0] {
    EV_TICK,
    EV_MODE,
    EV_SELECT,
    EV_UP,
    EV_DOWN,
    EV_SILENCE
  } event_t;

  typedef enum logic [1:0] {
    MODE_RUN,
    MODE_SET_TIME,
    MODE_SET_ALARM
  } mode_t;

  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [MinW-1:0]  seconds;
    logic             blink;
    logic [1:0]       mode;
    logic             field;
    logic [HourW-1:0] alarm_hour;
    logic [MinW-1:0]  alarm_minute;
    logic             sounding;
  } result_t;

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
    return (v >= top) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
    return (v == 6'd0 || v > top) ? top : v - 6'd1;
  endfunction

endpackage

@@ rtl/core/alarm_clock_time_counter_top.sv @@
// ----------------------------------------------------------------------------
// alarm_clock_time_counter_top - digital clock with alarm
// Event-driven clock: ticks, mode/select/up/down/silence buttons, one result
// per event.
// ----------------------------------------------------------------------------
// One transaction per clock cycle is sustained while out_ready stays high: an
// event passes an input register, the clock state is updated in the cycle it
// leaves that register, and the post-event view lands in the output register,
// which drives out_valid. The state update is a loop through the state
// registers of aclk_core, which sets both the rate and the clock frequency. The
// output register stalls only while out_ready is low; cfg_wr_data updates the
// tick prescaler (reset 977) and should be written with the block idle.
module alarm_clock_time_counter_top
  import aclk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_event_kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HourW-1:0]     out_hours,
  output logic [MinW-1:0]      out_minutes,
  output logic [MinW-1:0]      out_seconds,
  output logic                 out_blink,
  output logic [1:0]           out_mode,
  output logic                 out_field,
  output logic [HourW-1:0]     out_alarm_hour,
  output logic [MinW-1:0]      out_alarm_minute,
  output logic                 out_alarm_sounding,
  input  logic                 cfg_wr_en,
  input  logic [PrescaleW-1:0] cfg_wr_data
);

  logic [PrescaleW-1:0] prescale_r;
  logic                 s1_valid_r;
  logic [2:0]           s1_kind_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  result_t              core_res;
  logic                 advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  aclk_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .kind     (s1_kind_r),
    .prescale (prescale_r),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= PRESCALE_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prescale_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_event_kind;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hours          = out_res_r.hours;
  assign out_minutes        = out_res_r.minutes;
  assign out_seconds        = out_res_r.seconds;
  assign out_blink          = out_res_r.blink;
  assign out_mode           = out_res_r.mode;
  assign out_field          = out_res_r.field;
  assign out_alarm_hour     = out_res_r.alarm_hour;
  assign out_alarm_minute   = out_res_r.alarm_minute;
  assign out_alarm_sounding = out_res_r.sounding;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !advance)
    else $error("result overwritten before transaction completed");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item produced no result");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_kind_r))
    else $error("stalled event lost from input register");

endmodule

@@ rtl/core/aclk_core.sv @@
// ----------------------------------------------------------------------------
// aclk_core - clock, mode and alarm state
// Holds the timekeeping and alarm registers, applies one event per step and
// presents the post-event view for the result register.
// ----------------------------------------------------------------------------
module aclk_core
  import aclk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [2:0]           kind,
  input  logic [PrescaleW-1:0] prescale,
  output result_t              res
);

  logic [PrescaleW-1:0] tick_r,       tick_nxt;
  logic [MinW-1:0]      sec_r,        sec_nxt;
  logic [MinW-1:0]      min_r,        min_nxt;
  logic [HourW-1:0]     hour_r,       hour_nxt;
  logic [ShadowW-1:0]   shadow_r,     shadow_nxt;
  mode_t                mode_r,       mode_nxt;
  logic                 tfield_r,     tfield_nxt;
  logic                 afield_r,     afield_nxt;
  logic [HourW-1:0]     pend_hour_r,  pend_hour_nxt;
  logic [MinW-1:0]      pend_min_r,   pend_min_nxt;
  logic [HourW-1:0]     arm_hour_r,   arm_hour_nxt;
  logic [MinW-1:0]      arm_min_r,    arm_min_nxt;
  logic                 blink_r,      blink_nxt;

  logic [PrescaleW-1:0] tick_inc;
  logic                 up_dir;

  assign tick_inc = tick_r + 10'd1;
  assign up_dir   = (event_t'(kind) == EV_UP);

  always_comb begin
    tick_nxt      = tick_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    shadow_nxt    = shadow_r;
    mode_nxt      = mode_r;
    tfield_nxt    = tfield_r;
    afield_nxt    = afield_r;
    pend_hour_nxt = pend_hour_r;
    pend_min_nxt  = pend_min_r;
    arm_hour_nxt  = arm_hour_r;
    arm_min_nxt   = arm_min_r;
    blink_nxt     = blink_r;

    case (event_t'(kind))
      EV_TICK: begin
        if (tick_inc != prescale) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt  = '0;
          blink_nxt = ~blink_r;
          if (sec_r < SEC_MAX) begin
            sec_nxt = sec_r + 6'd1;
          end else begin
            // minute carry: shadow follows the clock's own minute
            sec_nxt    = '0;
            min_nxt    = wrap_up(min_r, MIN_MAX);
            shadow_nxt = {1'b0, min_nxt};
            if (min_nxt == '0) begin
              hour_nxt = HourW'(wrap_up({1'b0, hour_r}, HOUR_MAX));
            end
          end
        end
      end
      EV_MODE: begin
        case (mode_r)
          MODE_RUN:      mode_nxt = MODE_SET_TIME;
          MODE_SET_TIME: mode_nxt = MODE_SET_ALARM;
          default: begin
            mode_nxt     = MODE_RUN;
            arm_hour_nxt = pend_hour_r;
            arm_min_nxt  = pend_min_r;
            tfield_nxt   = 1'b0;
            afield_nxt   = 1'b0;
          end
        endcase
      end
      EV_SELECT: begin
        if (mode_r == MODE_SET_TIME) begin
          tfield_nxt = ~tfield_r;
        end else if (mode_r == MODE_SET_ALARM) begin
          afield_nxt = ~afield_r;
        end
      end
      EV_UP, EV_DOWN: begin
        if (mode_r == MODE_SET_TIME) begin
          if (!tfield_r) begin
            hour_nxt = up_dir ? HourW'(wrap_up({1'b0, hour_r}, HOUR_MAX))
                              : HourW'(wrap_down({1'b0, hour_r}, HOUR_MAX));
          end else begin
            min_nxt = up_dir ? wrap_up(min_r, MIN_MAX) : wrap_down(min_r, MIN_MAX);
          end
        end else if (mode_r == MODE_SET_ALARM) begin
          if (!afield_r) begin
            pend_hour_nxt = up_dir ? HourW'(wrap_up({1'b0, pend_hour_r}, HOUR_MAX))
                                   : HourW'(wrap_down({1'b0, pend_hour_r}, HOUR_MAX));
          end else begin
            pend_min_nxt = up_dir ? wrap_up(pend_min_r, MIN_MAX)
                                  : wrap_down(pend_min_r, MIN_MAX);
          end
        end
      end
      EV_SILENCE: shadow_nxt = SHADOW_CLEARED;
      default: ;
    endcase
  end

  always_comb begin
    res.hours        = hour_nxt;
    res.minutes      = min_nxt;
    res.seconds      = sec_nxt;
    res.blink        = blink_nxt;
    res.mode         = mode_nxt;
    res.field        = (mode_nxt == MODE_SET_TIME)  ? tfield_nxt :
                       (mode_nxt == MODE_SET_ALARM) ? afield_nxt : 1'b0;
    res.alarm_hour   = pend_hour_nxt;
    res.alarm_minute = pend_min_nxt;
    res.sounding     = (arm_hour_nxt == hour_nxt) && ({1'b0, arm_min_nxt} == shadow_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      shadow_r    <= SHADOW_CLEARED;
      mode_r      <= MODE_RUN;
      tfield_r    <= 1'b0;
      afield_r    <= 1'b0;
      pend_hour_r <= HOUR_UNSET;
      pend_min_r  <= '0;
      arm_hour_r  <= '0;
      arm_min_r   <= '0;
      blink_r     <= 1'b0;
    end else if (step) begin
      tick_r      <= tick_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      shadow_r    <= shadow_nxt;
      mode_r      <= mode_nxt;
      tfield_r    <= tfield_nxt;
      afield_r    <= afield_nxt;
      pend_hour_r <= pend_hour_nxt;
      pend_min_r  <= pend_min_nxt;
      arm_hour_r  <= arm_hour_nxt;
      arm_min_r   <= arm_min_nxt;
      blink_r     <= blink_nxt;
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r <= HourW'(HOUR_MAX)) && (min_r <= MIN_MAX) && (sec_r <= SEC_MAX))
    else $error("clock counter out of range");

  a_pend_hour: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_hour_r <= HourW'(HOUR_MAX)) || (pend_hour_r == HOUR_UNSET))
    else $error("pending alarm hour invalid");

  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    step && (event_t'(kind) == EV_SILENCE) |=> shadow_r == SHADOW_CLEARED)
    else $error("silence did not clear minute shadow");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(hour_r) && $stable(min_r) && $stable(shadow_r) && $stable(mode_r))
    else $error("state changed without a step");

endmodule
